/* src/sitrd_pkg.sv */
// ----------------------------------------------------------------------------
// sitrd_pkg
// Shared types, constants and helpers for the signed integer to radix digits
// unit: field widths, register indexes, sequencer states, alphabet lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package sitrd_pkg;

   // default largest radix
   localparam int MAX_RADIX_DEF = 16;

   // field widths
   localparam int VALUE_W  = 32;
   localparam int CHAR_W   = 8;
   localparam int LEN_W    = 5;
   localparam int CFG_W    = 64;
   localparam int ADDR_W   = 5;
   localparam int ALPHA_N  = 16;
   localparam int ALPHA_IW = 4;

   // quotient bits produced by the divider per cycle
   localparam int DIV_BITS  = 8;
   localparam int DIV_STEPS = VALUE_W / DIV_BITS;

   // digit stack depth and counter width
   localparam int STACK_N  = 32;
   localparam int STACK_IW = 5;
   localparam int COUNT_W  = 6;

   // register indexes
   localparam logic [1:0] REG_BASE_LENGTH = 2'd0;
   localparam logic [1:0] REG_DIGITS_LOW  = 2'd1;
   localparam logic [1:0] REG_DIGITS_HIGH = 2'd2;

   // characters with special meaning
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } state_type;

   // one character of the alphabet from the two packed words
   function automatic logic [CHAR_W-1:0] alpha_char(
      input logic [CFG_W-1:0]    lo_word,
      input logic [CFG_W-1:0]    hi_word,
      input logic [ALPHA_IW-1:0] idx
   );
      logic [2:0] sel;
      sel = idx[2:0];
      if (idx[3]) begin
         return hi_word[sel*CHAR_W +: CHAR_W];
      end
      return lo_word[sel*CHAR_W +: CHAR_W];
   endfunction

   // character that may not appear in an alphabet
   function automatic logic char_is_bad(input logic [CHAR_W-1:0] c);
      return (c == '0) || (c == CHAR_PLUS) || (c == CHAR_MINUS) ||
             ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
   endfunction

endpackage

`default_nettype wire

/* src/sitrd_div_step.sv */
// ----------------------------------------------------------------------------
// sitrd_div_step
// One step of the shared divider: takes the running remainder and the next
// slice of dividend bits and yields that slice of quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sitrd_div_step #(
   parameter int DIGIT_W = 4
) (
   input  wire logic [DIGIT_W-1:0]            rem_in,
   input  wire logic [sitrd_pkg::DIV_BITS-1:0] bits_in,
   input  wire logic [sitrd_pkg::LEN_W-1:0]   divisor,
   output      logic [DIGIT_W-1:0]            rem_out,
   output      logic [sitrd_pkg::DIV_BITS-1:0] quot_out
);
   import sitrd_pkg::*;

   // restoring division, msb first, remainder stays below the divisor
   always_comb begin
      logic [DIGIT_W-1:0] r;
      logic [DIGIT_W:0]   t;
      logic [LEN_W-1:0]   t_ext;
      r = rem_in;
      quot_out = '0;
      for (int k = DIV_BITS - 1; k >= 0; k--) begin
         t = {r, bits_in[k]};
         t_ext = LEN_W'(t);
         if (t_ext >= divisor) begin
            quot_out[k] = 1'b1;
            r = DIGIT_W'(t_ext - divisor);
         end else begin
            r = DIGIT_W'(t);
         end
      end
      rem_out = r;
   end

endmodule

`default_nettype wire

/* src/signed_integer_to_radix_digits_unit.sv */
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits_unit
// Converts a signed 32-bit word to its text in a programmable base.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one signed 32-bit value per word, taken only while idle.
//   rsp channel: one character per word, most significant digit first, a
//   leading '-' for negatives, tlast on the final character.
//   csr port: base_length at 0x00, digits_low_word at 0x08, digits_high_word
//   at 0x10. Program while idle. A bad alphabet drops the value silently.
// Steps per value: the value is accepted, the alphabet is checked (one
//   character against all later ones per cycle), each digit is divided
//   out in the shared divider (8 quotient bits per cycle), then the
//   characters go out, the sign first and the digits from the digit stack.
// The divider and the digit stack are the only arithmetic resources; the
// next value is taken once the last character sits in the output register.
// Reset clears the registers to zero and empties the output register.
// A stalled receiver holds the output register; the sequencer waits.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_integer_to_radix_digits_unit #(
   parameter int MAX_RADIX = sitrd_pkg::MAX_RADIX_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // value word: [31:0] value
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [sitrd_pkg::VALUE_W-1:0] req_tdata,
   // character word: [7:0] out_char; tlast carries last_char
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      logic [sitrd_pkg::CHAR_W-1:0]  rsp_tdata,
   output      logic                          rsp_tlast,
   // register port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [sitrd_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire logic [sitrd_pkg::CFG_W-1:0]   csr_pwdata,
   output      logic [sitrd_pkg::CFG_W-1:0]   csr_prdata,
   output      logic                          csr_pready
);
   import sitrd_pkg::*;

   localparam int DIGIT_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_RADIX);

   // configuration registers
   logic [LEN_W-1:0] base_length_ff;
   logic [CFG_W-1:0] digits_low_ff;
   logic [CFG_W-1:0] digits_high_ff;

   // sequencer registers
   state_type              state_ff, state_in;
   logic [ALPHA_IW-1:0]    chk_idx_ff, chk_idx_in;
   logic [VALUE_W-1:0]     work_ff, work_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [1:0]             step_ff, step_in;
   logic                   neg_ff, neg_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [DIGIT_W-1:0]     stack_ff [STACK_N];
   logic                   push;

   // output register
   logic                   out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]      out_char_ff, out_char_in;
   logic                   out_last_ff, out_last_in;

   // register port
   logic             csr_write;
   logic [1:0]       csr_index;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[ADDR_W-1:ADDR_W-2];

   always_ff @(posedge clock) begin
      if (reset) begin
         base_length_ff <= '0;
         digits_low_ff  <= '0;
         digits_high_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_BASE_LENGTH: base_length_ff <= csr_pwdata[LEN_W-1:0];
            REG_DIGITS_LOW:  digits_low_ff  <= csr_pwdata;
            REG_DIGITS_HIGH: digits_high_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_BASE_LENGTH: csr_prdata = CFG_W'(base_length_ff);
         REG_DIGITS_LOW:  csr_prdata = digits_low_ff;
         REG_DIGITS_HIGH: csr_prdata = digits_high_ff;
         default:         csr_prdata = '0;
      endcase
   end

   // shared divider step on the top slice of the working word
   logic [DIGIT_W-1:0]  div_rem;
   logic [DIV_BITS-1:0] div_quot;

   sitrd_div_step #(
      .DIGIT_W (DIGIT_W)
   ) u_div_step (
      .rem_in   (rem_ff),
      .bits_in  (work_ff[VALUE_W-1 -: DIV_BITS]),
      .divisor  (base_length_ff),
      .rem_out  (div_rem),
      .quot_out (div_quot)
   );

   // alphabet check of the current character against all later used ones
   logic [CHAR_W-1:0] chk_char;
   logic              chk_fail;
   always_comb begin
      chk_char = alpha_char(digits_low_ff, digits_high_ff, chk_idx_ff);
      chk_fail = char_is_bad(chk_char);
      for (int j = 0; j < ALPHA_N; j++) begin
         if ((ALPHA_IW'(j) > chk_idx_ff) && (LEN_W'(j) < base_length_ff) &&
             (alpha_char(digits_low_ff, digits_high_ff, ALPHA_IW'(j)) == chk_char)) begin
            chk_fail = 1'b1;
         end
      end
   end

   // digit at the top of the stack
   logic [COUNT_W-1:0] top_pos;
   logic [CHAR_W-1:0]  top_char;
   assign top_pos  = count_ff - COUNT_W'(1);
   assign top_char = alpha_char(digits_low_ff, digits_high_ff,
                                ALPHA_IW'(stack_ff[top_pos[STACK_IW-1:0]]));

   // sequencer
   logic slot_free;
   logic len_ok;
   assign slot_free = !out_valid_ff || rsp_tready;
   assign len_ok    = (base_length_ff >= LEN_W'(2)) && (base_length_ff <= MAX_LEN);

   always_comb begin
      state_in     = state_ff;
      chk_idx_in   = chk_idx_ff;
      work_in      = work_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      count_in     = count_ff;
      push         = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      req_tready   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               neg_in     = req_tdata[VALUE_W-1];
               work_in    = req_tdata[VALUE_W-1] ? (VALUE_W'(0) - req_tdata) : req_tdata;
               chk_idx_in = '0;
               rem_in     = '0;
               step_in    = '0;
               count_in   = '0;
               if (len_ok) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (chk_fail) begin
               state_in = ST_IDLE;
            end else if (LEN_W'(chk_idx_ff) == base_length_ff - LEN_W'(1)) begin
               state_in = ST_DIVIDE;
            end else begin
               chk_idx_in = chk_idx_ff + ALPHA_IW'(1);
            end
         end
         ST_DIVIDE: begin
            work_in = {work_ff[VALUE_W-DIV_BITS-1:0], div_quot};
            rem_in  = div_rem;
            step_in = step_ff + 2'd1;
            if (step_ff == 2'(DIV_STEPS - 1)) begin
               push     = 1'b1;
               rem_in   = '0;
               step_in  = '0;
               count_in = count_ff + COUNT_W'(1);
               if ((work_in == '0) || (count_in == COUNT_W'(STACK_N))) begin
                  state_in = neg_ff ? ST_SIGN : ST_EMIT;
               end
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_MINUS;
               out_last_in  = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = top_char;
               out_last_in  = (count_ff == COUNT_W'(1));
               count_in     = top_pos;
               if (count_ff == COUNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      chk_idx_ff  <= chk_idx_in;
      work_ff     <= work_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   // digit stack, least significant digit pushed first
   always_ff @(posedge clock) begin
      if (push) begin
         stack_ff[count_ff[STACK_IW-1:0]] <= div_rem;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

/* tb/tb_signed_integer_to_radix_digits_unit.sv */
// ----------------------------------------------------------------------------
// tb_signed_integer_to_radix_digits_unit
// Self-checking bench for the signed integer to radix digits unit. Values go
// in on the req stream, and every character word that comes out on the rsp
// stream is checked against a local conversion model that tracks the
// alphabet registers. Directed cases cover both ends of the value range,
// bases 2 and 16, and each kind of rejected alphabet. A long receiver
// hold-off follows, then random phases with random alphabets, random idle
// gaps on both sides and sender pauses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_signed_integer_to_radix_digits_unit;
   import sitrd_pkg::*;

   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int SETTLE_CYCLES   = 300;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_VALUES   = 60;
   localparam int PHASE_VALUES    = 15;
   localparam int MAX_PHASES      = 8;

   // register index with no register behind it
   localparam logic [1:0] REG_UNUSED = 2'd3;

   localparam logic [CHAR_W-1:0] NUL_CHAR = 8'h00;
   localparam logic [CHAR_W-1:0] VT_CHAR  = 8'h0B;

   localparam logic [31:0] INT_MIN = 32'h8000_0000;
   localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] MINUS_1 = 32'hFFFF_FFFF;

   // "0".."9" with junk above the used length, junk includes forbidden bytes
   localparam logic [127:0] DEC_DIGITS = {64'h2B2D_0020_3130_3938,
                                          64'h3736_3534_3332_3130};
   // "01" with forbidden bytes and repeats above the used length
   localparam logic [127:0] BIN_DIGITS = {64'h0000_3130_FFFF_0A0A,
                                          64'h2D2B_2000_0D09_3130};
   // "0".."9" "A".."F"
   localparam logic [127:0] HEX_DIGITS = {64'h4645_4443_4241_3938,
                                          64'h3736_3534_3332_3130};

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } char_word_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [VALUE_W-1:0]  req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [CHAR_W-1:0]   rsp_tdata;
   logic                rsp_tlast;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [ADDR_W-1:0]   csr_paddr;
   logic [CFG_W-1:0]    csr_pwdata;
   logic [CFG_W-1:0]    csr_prdata;
   logic                csr_pready;

   // shadow copy of the alphabet registers
   logic [LEN_W-1:0]    cfg_radix;
   logic [CFG_W-1:0]    cfg_low;
   logic [CFG_W-1:0]    cfg_high;

   char_word_type       pending_chars[$];
   int                  req_gap_max;
   int                  rsp_gap_max;
   bit                  hold_off_pending;
   int                  error_count;
   int                  values_sent;
   int                  values_converted;
   int                  chars_checked;
   int                  alphabets_programmed;
   int                  quiet_cycles;

   signed_integer_to_radix_digits_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // conversion model
   // ------------------------------------------------------------------------

   function automatic logic forbidden_digit(input logic [CHAR_W-1:0] c);
      return (c == NUL_CHAR) || (c == CHAR_PLUS) || (c == CHAR_MINUS) ||
             ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
   endfunction

   function automatic logic [CHAR_W-1:0] digit_glyph(input logic [3:0] idx);
      if (idx[3]) begin
         return cfg_high[idx[2:0]*CHAR_W +: CHAR_W];
      end
      return cfg_low[idx[2:0]*CHAR_W +: CHAR_W];
   endfunction

   // length in range, no forbidden or repeated character among the used ones
   function automatic logic alphabet_valid();
      int i;
      int j;
      if ((cfg_radix < 2) || (cfg_radix > MAX_RADIX_DEF)) begin
         return 1'b0;
      end
      for (i = 0; i < cfg_radix; i++) begin
         if (forbidden_digit(digit_glyph(4'(i)))) begin
            return 1'b0;
         end
         for (j = i + 1; j < cfg_radix; j++) begin
            if (digit_glyph(4'(j)) == digit_glyph(4'(i))) begin
               return 1'b0;
            end
         end
      end
      return 1'b1;
   endfunction

   // queue the characters one value turns into
   task automatic predict_text(input logic [31:0] value);
      logic [32:0]   mag;
      logic [3:0]    digs [32];
      int            nd;
      int            i;
      char_word_type w;
      if (!alphabet_valid()) begin
         return;
      end
      values_converted++;
      // magnitude one bit wider so the most negative value survives
      mag = value[31] ? (33'h1_0000_0000 - {1'b0, value}) : {1'b0, value};
      nd  = 0;
      forever begin
         digs[nd] = 4'(mag % cfg_radix);
         nd++;
         mag = mag / cfg_radix;
         if ((mag == 0) || (nd >= 32)) break;
      end
      if (value[31]) begin
         w.ch   = CHAR_MINUS;
         w.last = 1'b0;
         pending_chars.push_back(w);
      end
      for (i = nd - 1; i >= 0; i--) begin
         w.ch   = digit_glyph(digs[i]);
         w.last = (i == 0);
         pending_chars.push_back(w);
      end
   endtask

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   function automatic logic [31:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         case ($urandom_range(0, 3))
            0:       return INT_MIN;
            1:       return INT_MAX;
            2:       return MINUS_1;
            default: return 32'd0;
         endcase
      end
      if (sel <= 2) begin
         return $urandom_range(0, 80) - 32'd40;
      end
      return $urandom;
   endfunction

   function automatic logic [CHAR_W-1:0] pick_forbidden();
      case ($urandom_range(0, 4))
         0:       return NUL_CHAR;
         1:       return CHAR_PLUS;
         2:       return CHAR_MINUS;
         3:       return CHAR_SPACE;
         default: return 8'($urandom_range(CHAR_TAB, CHAR_CR));
      endcase
   endfunction

   function automatic logic [127:0] with_byte(input logic [127:0] chars, input int pos,
                                              input logic [CHAR_W-1:0] b);
      logic [127:0] r;
      r = chars;
      r[pos*CHAR_W +: CHAR_W] = b;
      return r;
   endfunction

   // one value word; tvalid stays high on return so back-to-back words need no gap
   task automatic send_value(input logic [31:0] value);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = value;
      req_tvalid = 1'b1;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      predict_text(value);
      values_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending_chars.size() != 0) @(negedge clock);
   endtask

   // drained, then let a dropped value finish its alphabet check
   task automatic settle_block();
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [CFG_W-1:0] data);
      req_tvalid  = 1'b0;
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 3'b000};
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      forever begin
         @(posedge clock);
         if (csr_pready) break;
      end
      case (idx)
         REG_BASE_LENGTH: cfg_radix = data[LEN_W-1:0];
         REG_DIGITS_LOW:  cfg_low   = data;
         REG_DIGITS_HIGH: cfg_high  = data;
         default: ;
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic csr_check(input logic [1:0] idx, input logic [CFG_W-1:0] want);
      req_tvalid  = 1'b0;
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = {idx, 3'b000};
      @(negedge clock);
      csr_penable = 1'b1;
      forever begin
         @(posedge clock);
         if (csr_pready) break;
      end
      if (csr_prdata !== want) begin
         error_count++;
         $error("csr_prdata at index %0d: expected %h, actual %h", idx, want, csr_prdata);
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic check_registers();
      csr_check(REG_BASE_LENGTH, {{(CFG_W-LEN_W){1'b0}}, cfg_radix});
      csr_check(REG_DIGITS_LOW, cfg_low);
      csr_check(REG_DIGITS_HIGH, cfg_high);
   endtask

   task automatic program_alphabet(input logic [127:0] chars, input logic [CFG_W-1:0] len_word);
      settle_block();
      csr_write(REG_DIGITS_LOW, chars[63:0]);
      csr_write(REG_DIGITS_HIGH, chars[127:64]);
      csr_write(REG_BASE_LENGTH, len_word);
      check_registers();
      alphabets_programmed++;
   endtask

   // random distinct legal digits, junk past the length, optionally broken
   task automatic program_random_alphabet(input int len, input bit make_bad);
      logic [127:0]      chars;
      logic [CFG_W-1:0]  len_word;
      logic [CHAR_W-1:0] b;
      bit                fresh;
      int                i;
      int                j;
      int                pos;
      chars    = {$urandom, $urandom, $urandom, $urandom};
      len_word = {$urandom, $urandom};
      len_word[LEN_W-1:0] = LEN_W'(len);
      for (i = 0; i < len; i++) begin
         forever begin
            b     = 8'($urandom_range(0, 255));
            fresh = !forbidden_digit(b);
            for (j = 0; j < i; j++) begin
               if (chars[j*CHAR_W +: CHAR_W] == b) fresh = 1'b0;
            end
            if (fresh) break;
         end
         chars[i*CHAR_W +: CHAR_W] = b;
      end
      if (make_bad) begin
         pos = $urandom_range(0, len - 1);
         case ($urandom_range(0, 2))
            0: chars = with_byte(chars, pos, pick_forbidden());
            1: begin
               j     = (pos + 1 + $urandom_range(0, len - 2)) % len;
               chars = with_byte(chars, pos, chars[j*CHAR_W +: CHAR_W]);
            end
            default: begin
               if ($urandom_range(0, 1) == 0) begin
                  len_word[LEN_W-1:0] = LEN_W'($urandom_range(0, 1));
               end else begin
                  len_word[LEN_W-1:0] = LEN_W'($urandom_range(17, 31));
               end
            end
         endcase
      end
      program_alphabet(chars, len_word);
   endtask

   task automatic try_alphabet(input logic [127:0] chars, input logic [CFG_W-1:0] len_word);
      program_alphabet(chars, len_word);
      send_value(pick_value());
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // registers come up zero, so the empty alphabet drops every value
   task automatic test_reset_alphabet();
      check_registers();
      send_value(32'd0);
      send_value(32'hFFFF_FFFB);
   endtask

   task automatic test_decimal_extremes();
      program_alphabet(DEC_DIGITS, 64'd10);
      send_value(32'd0);
      send_value(MINUS_1);
      send_value(32'd10);
      send_value(INT_MAX);
      send_value(INT_MIN);
   endtask

   // longest texts in base 2, then base 16 set through a length word with
   // upper bits that the register drops
   task automatic test_radix_extremes();
      program_alphabet(BIN_DIGITS, 64'd2);
      send_value(INT_MIN);
      send_value(INT_MAX);
      program_alphabet(HEX_DIGITS, 64'hFFFF_FFFF_FFFF_FFF0);
      send_value(INT_MIN);
      send_value(MINUS_1);
   endtask

   // a write above the last register changes nothing
   task automatic test_unused_register();
      settle_block();
      csr_write(REG_UNUSED, {$urandom, $urandom});
      check_registers();
      send_value(pick_value());
   endtask

   task automatic test_rejected_alphabets();
      try_alphabet(HEX_DIGITS, 64'd1);
      try_alphabet(HEX_DIGITS, 64'd17);
      try_alphabet(HEX_DIGITS, 64'd31);
      // repeated digit
      try_alphabet(with_byte(HEX_DIGITS, 15, HEX_DIGITS[7:0]), 64'd16);
      // each forbidden byte somewhere in the used range
      try_alphabet(with_byte(HEX_DIGITS, 0, NUL_CHAR), 64'd16);
      try_alphabet(with_byte(HEX_DIGITS, 15, CHAR_PLUS), 64'd16);
      try_alphabet(with_byte(HEX_DIGITS, 7, CHAR_MINUS), 64'd16);
      try_alphabet(with_byte(HEX_DIGITS, 8, CHAR_TAB), 64'd16);
      try_alphabet(with_byte(HEX_DIGITS, 3, VT_CHAR), 64'd16);
      try_alphabet(with_byte(HEX_DIGITS, 12, CHAR_CR), 64'd16);
      try_alphabet(with_byte(HEX_DIGITS, 5, CHAR_SPACE), 64'd16);
      // forbidden byte just past the length is ignored
      try_alphabet(with_byte(HEX_DIGITS, 15, CHAR_MINUS), 64'd15);
   endtask

   // receiver stops for a long stretch while the sender keeps offering
   task automatic test_receiver_hold_off();
      program_alphabet(BIN_DIGITS, 64'd2);
      req_gap_max      = 0;
      hold_off_pending = 1'b1;
      repeat (8) send_value({1'b1, 31'($urandom)});
      wait_drained();
      req_gap_max = 19;
   endtask

   task automatic test_random_traffic();
      int phase;
      int i;
      int len;
      int base_count;
      phase      = 0;
      base_count = values_converted;
      while ((values_converted - base_count < RANDOM_VALUES) && (phase < MAX_PHASES)) begin
         if (phase == 0) begin
            len = 2;
         end else if (phase == 1) begin
            len = MAX_RADIX_DEF;
         end else begin
            len = $urandom_range(2, MAX_RADIX_DEF);
         end
         program_random_alphabet(len, (phase == 4) || ($urandom_range(0, 5) == 0));
         // idle pattern per phase: both, none, sender only, receiver only
         case (phase % 4)
            0: begin req_gap_max = 19; rsp_gap_max = 19; end
            1: begin req_gap_max = 0;  rsp_gap_max = 0;  end
            2: begin req_gap_max = 19; rsp_gap_max = 0;  end
            default: begin req_gap_max = 0; rsp_gap_max = 19; end
         endcase
         for (i = 0; i < PHASE_VALUES; i++) begin
            // sender waits for the output to drain now and then
            if ((i == 7) || ($urandom_range(0, 9) == 0)) wait_drained();
            send_value(pick_value());
         end
         phase++;
      end
      req_gap_max = 19;
      rsp_gap_max = 19;
   endtask

   // ------------------------------------------------------------------------
   // result checker, random stalls and the long hold-off
   // ------------------------------------------------------------------------
   initial begin
      int            stall;
      char_word_type w;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (hold_off_pending) begin
            rsp_tready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_pending = 1'b0;
         end
         stall = $urandom_range(0, rsp_gap_max);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         forever begin
            @(posedge clock);
            if (rsp_tvalid) break;
         end
         chars_checked++;
         if (pending_chars.size() == 0) begin
            error_count++;
            $error("rsp word with nothing expected: out_char %h, last_char %b",
                   rsp_tdata, rsp_tlast);
         end else begin
            w = pending_chars.pop_front();
            if (rsp_tdata !== w.ch) begin
               error_count++;
               $error("out_char: expected %h, actual %h", w.ch, rsp_tdata);
            end
            if (rsp_tlast !== w.last) begin
               error_count++;
               $error("last_char: expected %b, actual %b", w.last, rsp_tlast);
            end
         end
         @(negedge clock);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d characters still expected",
                  quiet_cycles, pending_chars.size());
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      req_tvalid           = 1'b0;
      req_tdata            = '0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      cfg_radix            = '0;
      cfg_low              = '0;
      cfg_high             = '0;
      req_gap_max          = 19;
      rsp_gap_max          = 19;
      hold_off_pending     = 1'b0;
      error_count          = 0;
      values_sent          = 0;
      values_converted     = 0;
      chars_checked        = 0;
      alphabets_programmed = 0;
      quiet_cycles         = 0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      test_reset_alphabet();
      test_decimal_extremes();
      test_radix_extremes();
      test_unused_register();
      test_rejected_alphabets();
      test_receiver_hold_off();
      test_random_traffic();

      settle_block();
      $display("covered %0d values (%0d converted, the rest dropped) and %0d characters",
               values_sent, values_converted, chars_checked);
      $display("over %0d alphabet settings, radix 2 to 16 plus rejected ones, with stalls",
               alphabets_programmed);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire
